### rtl/srpr_pkg.sv
`timescale 1ns / 1ps

package srpr_pkg;

	localparam int NW  = 14;       // nside
	localparam int ZW  = 18;       // height, Q1.16 signed
	localparam int RW  = 15;       // ring index
	localparam int PW  = 30;       // pixel index
	localparam int DW  = 15;       // cap distance 1-|z|, at most 21845
	localparam int AW  = 42;       // sqrt radicand 3*dist*n^2
	localparam int QW  = AW / 2;   // root width, one bit per sqrt stage
	localparam int RMW = QW + 2;   // sqrt remainder

	localparam int Q_ONE     = 65536;
	localparam int CAP_LIMIT = 43691;

	typedef enum logic [1:0] {
		ZONE_NORTH = 2'd0,
		ZONE_EQ    = 2'd1,
		ZONE_SOUTH = 2'd2
	} zone_t;

	typedef struct packed {
		zone_t          zone;
		logic [RW-1:0]  ring_eq;
	} sqrt_tag_t;

endpackage

### rtl/sphere_ring_pixel_range.sv
`timescale 1ns / 1ps
// An accepted height beat passes every stage in order to the output register.
// Throughput: one beat per cycle; the 21-stage square root pipeline (one root bit
// per stage) sets the depth, and the whole pipeline holds while the output is stalled.
// Reset (arst_n low, asynchronous): all stage valids clear, grid_resolution returns to 1.
// grid_resolution is clamped to 1..NSIDE_MAX as it is written.
module sphere_ring_pixel_range #(
	parameter int NSIDE_MAX = 8192
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          grid_resolution_we,
	input  logic [srpr_pkg::NW-1:0]       grid_resolution,
	input  logic                          height_valid,
	output logic                          height_stall,
	input  logic signed [srpr_pkg::ZW-1:0] height_z,
	output logic                          ring_valid,
	input  logic                          ring_stall,
	output logic [srpr_pkg::RW-1:0]       ring_number,
	output logic [srpr_pkg::PW-1:0]       pixel_first,
	output logic [srpr_pkg::PW-1:0]       pixel_last
);
	import srpr_pkg::*;

	localparam logic [NW-1:0]        N_MAX  = NW'(NSIDE_MAX);
	localparam logic signed [ZW-1:0] Z_HI   = ZW'(Q_ONE);
	localparam logic signed [ZW-1:0] Z_LO   = ZW'(-Q_ONE);
	localparam logic signed [ZW-1:0] Z_CAP  = ZW'(CAP_LIMIT);
	localparam logic signed [ZW-1:0] Z_NCAP = ZW'(-CAP_LIMIT);

	// resolution register
	logic [NW-1:0] n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(1);
		end else if (grid_resolution_we) begin
			if (grid_resolution == '0)
				n_q <= NW'(1);
			else if (grid_resolution > N_MAX)
				n_q <= N_MAX;
			else
				n_q <= grid_resolution;
		end
	end

	// global advance: everything moves unless the output beat is held
	logic en;
	assign en           = !(ring_valid && ring_stall);
	assign height_stall = !en;

	// stage 1: clamp, classify, n^2 and equatorial product
	logic signed [ZW-1:0] zc;
	logic [16:0]          absz;
	logic [16:0]          dist_full;
	logic signed [20:0]   num_w;
	zone_t                zone;

	always_comb begin
		if (height_z > Z_HI)
			zc = Z_HI;
		else if (height_z < Z_LO)
			zc = Z_LO;
		else
			zc = height_z;
		if (zc >= Z_CAP)
			zone = ZONE_NORTH;
		else if (zc <= Z_NCAP)
			zone = ZONE_SOUTH;
		else
			zone = ZONE_EQ;
		absz      = zc[ZW-1] ? 17'(-zc) : 17'(zc);
		dist_full = 17'(Q_ONE) - absz;
		num_w     = 21'sd262144 - 21'sd3 * 21'(zc);
	end

	logic          v_s1;
	zone_t         zone_s1;
	logic [DW-1:0] dist_s1;
	logic [26:0]   nn_s1;
	logic [31:0]   eqp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= height_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zone_s1 <= zone;
			dist_s1 <= (zone == ZONE_EQ) ? '0 : dist_full[DW-1:0];
			nn_s1   <= 27'(n_q) * 27'(n_q);
			eqp_s1  <= 32'(n_q) * 32'(num_w[18:0]);
		end
	end

	// stage 2: radicand 3*dist*n^2, equatorial ring
	logic [15:0] dist3;
	logic [31:0] eq_sum;

	assign dist3  = ({1'b0, dist_s1} << 1) + {1'b0, dist_s1};
	assign eq_sum = eqp_s1 + 32'd65536;

	logic          v_s2;
	logic [AW-1:0] a_s2;
	sqrt_tag_t     tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2           <= AW'(dist3) * AW'(nn_s1);
			tag_s2.zone    <= zone_s1;
			tag_s2.ring_eq <= eq_sum[31:17];
		end
	end

	// stages 3..23: square root
	logic          v_s23;
	logic [QW-1:0] root_s23;
	sqrt_tag_t     tag_s23;

	srpr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s2),
		.in_a     (a_s2),
		.in_tag   (tag_s2),
		.out_vld  (v_s23),
		.out_root (root_s23),
		.out_tag  (tag_s23)
	);

	// stage 24: round the root, pick ring
	logic [QW:0]   rsum;
	logic [NW-1:0] rcap;
	logic [RW-1:0] ring;
	logic [15:0]   n4;

	always_comb begin
		rsum = {1'b0, root_s23} + (QW+1)'(128);
		rcap = rsum[QW:8];
		if (rcap == '0)
			rcap = NW'(1);
		n4 = {n_q, 2'b00};
		case (tag_s23.zone)
			ZONE_NORTH: ring = RW'(rcap);
			ZONE_SOUTH: ring = RW'(n4 - 16'(rcap));
			ZONE_EQ:    ring = tag_s23.ring_eq;
			default:    ring = tag_s23.ring_eq;
		endcase
	end

	logic          v_s24;
	logic [RW-1:0] ring_s24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s24 <= 1'b0;
		else if (en)
			v_s24 <= v_s23;
	end

	always_ff @(posedge clk) begin
		if (en)
			ring_s24 <= ring;
	end

	// stage 25: per-band products
	logic [15:0] n16, n3, r16, op_x, op_y, cnt;
	zone_t       band;

	always_comb begin
		n16 = 16'(n_q);
		n3  = (n16 << 1) + n16;
		r16 = 16'(ring_s24);
		if (r16 < n16) begin
			band = ZONE_NORTH;
			op_x = r16;
			op_y = r16 - 16'd1;
			cnt  = r16;
		end else if (r16 > n3) begin
			band = ZONE_SOUTH;
			op_x = (n16 << 2) - r16;
			op_y = op_x + 16'd1;
			cnt  = op_x;
		end else begin
			band = ZONE_EQ;
			op_x = n16;
			op_y = r16 - n16;
			cnt  = n16;
		end
	end

	logic          v_s25;
	logic [RW-1:0] ring_s25;
	zone_t         band_s25;
	logic [31:0]   prod_s25;
	logic [27:0]   nm1_s25;
	logic [15:0]   cnt_s25;
	logic [NW-1:0] n_s25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s25 <= 1'b0;
		else if (en)
			v_s25 <= v_s24;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s25 <= ring_s24;
			band_s25 <= band;
			prod_s25 <= 32'(op_x) * 32'(op_y);
			nm1_s25  <= 28'(n_q) * 28'(n_q - NW'(1));
			cnt_s25  <= cnt;
			n_s25    <= n_q;
		end
	end

	// stage 26: pixel bounds, output register
	logic [31:0] nsq, first, last;

	always_comb begin
		nsq = 32'(nm1_s25) + 32'(n_s25);
		case (band_s25)
			ZONE_NORTH: first = prod_s25 << 1;
			ZONE_EQ:    first = (32'(nm1_s25) << 1) + (prod_s25 << 2);
			ZONE_SOUTH: first = (nsq << 3) + (nsq << 2) - (prod_s25 << 1);
			default:    first = prod_s25 << 1;
		endcase
		last = first + (32'(cnt_s25) << 2) - 32'd1;
	end

	logic          v_s26;
	logic [RW-1:0] ring_s26;
	logic [PW-1:0] first_s26, last_s26;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s26 <= 1'b0;
		else if (en)
			v_s26 <= v_s25;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s26  <= ring_s25;
			first_s26 <= first[PW-1:0];
			last_s26  <= last[PW-1:0];
		end
	end

	assign ring_valid  = v_s26;
	assign ring_number = ring_s26;
	assign pixel_first = first_s26;
	assign pixel_last  = last_s26;

endmodule

### rtl/srpr_isqrt.sv
`timescale 1ns / 1ps

// Restoring integer square root, one root bit per stage.
module srpr_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [srpr_pkg::AW-1:0] in_a,
	input  srpr_pkg::sqrt_tag_t    in_tag,
	output logic                   out_vld,
	output logic [srpr_pkg::QW-1:0] out_root,
	output srpr_pkg::sqrt_tag_t    out_tag
);
	import srpr_pkg::*;

	logic [AW-1:0]  a_s    [QW-1];
	logic [RMW-1:0] rem_s  [QW-1];
	logic [QW-1:0]  root_s [QW];
	sqrt_tag_t      tag_s  [QW];
	logic [QW-1:0]  vld_s;

	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_stage
			localparam int P = 2 * (QW - 1 - i);
			logic [AW-1:0]  a_in;
			logic [RMW-1:0] rem_in;
			logic [QW-1:0]  root_in;
			sqrt_tag_t      tag_in;
			logic           vld_in;
			logic [RMW+1:0] shl;
			logic [RMW+1:0] trial;
			logic [RMW+1:0] diff;
			logic           ge;
			logic [RMW-1:0] rem_nxt;
			logic [QW-1:0]  root_nxt;

			if (i == 0) begin : g_first
				assign a_in    = in_a;
				assign rem_in  = '0;
				assign root_in = '0;
				assign tag_in  = in_tag;
				assign vld_in  = in_vld;
			end else begin : g_rest
				assign a_in    = a_s[i-1];
				assign rem_in  = rem_s[i-1];
				assign root_in = root_s[i-1];
				assign tag_in  = tag_s[i-1];
				assign vld_in  = vld_s[i-1];
			end

			always_comb begin
				shl      = {rem_in, a_in[P+1:P]};
				trial    = (RMW+2)'({root_in, 2'b01});
				diff     = shl - trial;
				ge       = (shl >= trial);
				rem_nxt  = ge ? diff[RMW-1:0] : shl[RMW-1:0];
				root_nxt = {root_in[QW-2:0], ge};
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[i] <= root_nxt;
					tag_s[i]  <= tag_in;
				end
			end

			if (i < QW - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						a_s[i]   <= a_in;
						rem_s[i] <= rem_nxt;
					end
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[QW-1];
	assign out_root = root_s[QW-1];
	assign out_tag  = tag_s[QW-1];

endmodule

### rtl/srpr_chk.sv
`timescale 1ns / 1ps

module srpr_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           height_stall,
	input logic                           ring_valid,
	input logic                           ring_stall,
	input logic [srpr_pkg::RW-1:0]        ring_number,
	input logic [srpr_pkg::PW-1:0]        pixel_first,
	input logic [srpr_pkg::PW-1:0]        pixel_last
);

	// held output beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ring_valid && ring_stall |=> ring_valid && $stable(ring_number)
			&& $stable(pixel_first) && $stable(pixel_last))
		else $error("output beat changed while stalled");

	// input backs off only when the output is held
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		height_stall |-> ring_valid && ring_stall)
		else $error("input stalled without output stall");

	a_ring_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ring_valid |-> ring_number != '0)
		else $error("ring zero");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		ring_valid |-> pixel_last >= pixel_first)
		else $error("pixel range inverted");

	// ring one always starts at pixel zero
	a_first_ring: assert property (@(posedge clk) disable iff (!arst_n)
		ring_valid && ring_number == srpr_pkg::RW'(1) |-> pixel_first == '0)
		else $error("first ring does not start at zero");

endmodule

bind sphere_ring_pixel_range srpr_chk u_srpr_chk (.*);
